@@ rtl/tcc_pkg.sv @@
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared types, angle constants, the CORDIC arctangent table and unit conversion.
// ---------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   // angles are signed degrees * 2^16; FULL_TURN and the limits are in 1/128 degree
   localparam int ZW           = 26;
   localparam int ATAN_ENTRIES = 24;
   localparam int ACC_GUARD    = 14;
   localparam int FULL_TURN    = 46080;
   localparam int ROLL_MAX     = 23040;
   localparam int PITCH_MAX    = 11520;

   typedef logic signed [ZW-1:0] angle_type;
   typedef logic signed [16:0]   units_type;

   localparam angle_type DEG180 = 26'sd11796480;
   localparam angle_type DEG90  = 26'sd5898240;

   // 2^30 / K, K being the limit gain
   localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

   // atan(2^-i) in degrees * 2^16, rounded to nearest
   function automatic angle_type atan_q16(input int idx);
      case (idx)
         0:       return 26'sd2949120;
         1:       return 26'sd1740967;
         2:       return 26'sd919879;
         3:       return 26'sd466945;
         4:       return 26'sd234379;
         5:       return 26'sd117304;
         6:       return 26'sd58666;
         7:       return 26'sd29335;
         8:       return 26'sd14668;
         9:       return 26'sd7334;
         10:      return 26'sd3667;
         11:      return 26'sd1833;
         12:      return 26'sd917;
         13:      return 26'sd458;
         14:      return 26'sd229;
         15:      return 26'sd115;
         16:      return 26'sd57;
         17:      return 26'sd29;
         18:      return 26'sd14;
         19:      return 26'sd7;
         20:      return 26'sd4;
         21:      return 26'sd2;
         22:      return 26'sd1;
         default: return 26'sd0;
      endcase
   endfunction

   // degrees * 2^16 to 1/128 degree, rounded half up
   function automatic units_type to_units(input angle_type a);
      angle_type t;
      t = a + 26'sd256;
      return 17'(t >>> 9);
   endfunction

endpackage

`default_nettype wire

@@ rtl/tcc_cordic.sv @@
// ---------------------------------------------------------------------------
// tcc_cordic
// Pipelined CORDIC, one iteration per stage; vectoring or rotation mode.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_cordic #(
   parameter int W      = 34,
   parameter int STAGES = 16,
   parameter bit ROTATE = 1'b0,
   parameter int SIDE_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [W-1:0]    in_x,
   input  logic signed [W-1:0]    in_y,
   input  tcc_pkg::angle_type     in_z,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic signed [W-1:0]    out_x,
   output logic signed [W-1:0]    out_y,
   output tcc_pkg::angle_type     out_z,
   output logic [SIDE_W-1:0]      out_side
);
   import tcc_pkg::*;

   localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;
   localparam logic signed [W-1:0] X_START = W'(INV_GAIN_Q30);

   logic                valid_ff [0:N];
   logic signed [W-1:0] x_ff     [0:N];
   logic signed [W-1:0] y_ff     [0:N];
   angle_type           z_ff     [0:N];
   logic                flag_ff  [0:N];  // vectoring: zero vector; rotation: folded
   logic [SIDE_W-1:0]   side_ff  [0:N];

   logic signed [W-1:0] x0_in, y0_in;
   angle_type           z0_in;
   logic                flag0_in;

   logic                out_valid_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff;
   angle_type           out_z_ff;
   logic [SIDE_W-1:0]   out_side_ff;

   // entry: quadrant fold
   always_comb begin
      x0_in    = in_x;
      y0_in    = in_y;
      z0_in    = '0;
      flag0_in = 1'b0;
      if (ROTATE) begin
         x0_in = X_START;
         y0_in = '0;
         z0_in = in_z;
         if (in_z > DEG90) begin
            z0_in    = in_z - DEG180;
            flag0_in = 1'b1;
         end else if (in_z < -DEG90) begin
            z0_in    = in_z + DEG180;
            flag0_in = 1'b1;
         end
      end else begin
         flag0_in = (in_x == '0) && (in_y == '0);
         if (in_x < 0) begin
            x0_in = -in_x;
            y0_in = -in_y;
            z0_in = (in_y >= 0) ? DEG180 : -DEG180;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < N; i++) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
      x_ff[0]    <= x0_in;
      y_ff[0]    <= y0_in;
      z_ff[0]    <= z0_in;
      flag_ff[0] <= flag0_in;
      side_ff[0] <= in_side;
      for (int i = 0; i < N; i++) begin
         // up: vectoring with y >= 0, or rotation with z < 0
         if (ROTATE ? (z_ff[i] < 0) : (y_ff[i] >= 0)) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q16(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q16(i);
         end
         flag_ff[i+1] <= flag_ff[i];
         side_ff[i+1] <= side_ff[i];
      end
   end

   // exit: undo the fold / force zero-vector angle
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[N];
      end
      out_x_ff    <= (ROTATE && flag_ff[N]) ? -x_ff[N] : x_ff[N];
      out_y_ff    <= (ROTATE && flag_ff[N]) ? -y_ff[N] : y_ff[N];
      out_z_ff    <= (!ROTATE && flag_ff[N]) ? '0 : z_ff[N];
      out_side_ff <= side_ff[N];
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;
   assign out_side  = out_side_ff;

endmodule

`default_nettype wire

@@ rtl/tilt_compensated_compass_core.sv @@
// ---------------------------------------------------------------------------
// tilt_compensated_compass_core
// Roll, pitch and tilt-compensated heading from accel and mag vectors.
// ---------------------------------------------------------------------------
// Usage:
//   Input word: req_accel_x/y/z and req_mag_x/y/z, taken at each clock edge
//   with start high and busy low. busy is always low: a new word may enter
//   every cycle.
//   Result word: rsp_roll, rsp_pitch, rsp_heading, shown for one cycle with
//   rsp_strobe high, in input order, one result per input word.
//   Config: csr_write_en/csr_write_data set the declination (1/128 degree);
//   write it only while no word is in flight.
//   Pipeline: four CORDIC pipelines in series (roll, pitch, the two
//   sin/cos units side by side, heading), each N + 2 stages with
//   N = min(CORDIC_STAGES, 24), plus two magnitude scale, four product
//   and two output stages.
//   Throughput: one word per cycle.
//   Reset clears every valid bit and loads the declination with 128; words
//   in flight are dropped. The receiver cannot stall, so nothing waits.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_compensated_compass_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [16:0]  req_mag_x,
   input  logic signed [16:0]  req_mag_y,
   input  logic signed [16:0]  req_mag_z,
   input  logic                csr_write_en,
   input  logic signed [15:0]  csr_write_data,
   output logic                rsp_strobe,
   output logic signed [15:0]  rsp_roll,
   output logic signed [14:0]  rsp_pitch,
   output logic [15:0]         rsp_heading
);
   import tcc_pkg::*;

   localparam int AW   = 34;  // accel path, raw << 14 plus CORDIC growth
   localparam int HW   = 54;  // compensated mag path
   localparam int MAGW = 51;  // three 17-bit mag components

   // ---- declination register ----
   logic signed [15:0] csr_decl_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_decl_ff <= 16'sd128;
      end else if (csr_write_en) begin
         csr_decl_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // ---- roll: vectoring on (az, ay) ----
   logic                 c1_valid;
   logic signed [AW-1:0] c1_mag;
   angle_type            c1_roll;
   logic [16+MAGW-1:0]   c1_side;

   tcc_cordic #(.W(AW), .STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(16+MAGW)) u_roll (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_x     (AW'(req_accel_z) <<< ACC_GUARD),
      .in_y     (AW'(req_accel_y) <<< ACC_GUARD),
      .in_z     ('0),
      .in_side  ({req_accel_x, req_mag_x, req_mag_y, req_mag_z}),
      .out_valid(c1_valid),
      .out_x    (c1_mag),
      .out_y    (),
      .out_z    (c1_roll),
      .out_side (c1_side)
   );

   // ---- magnitude scale by 1/K: product, then round ----
   logic                    m1_valid_ff, m2_valid_ff;
   logic signed [AW+31:0]   m1_prod_ff;
   angle_type               m1_roll_ff, m2_roll_ff;
   logic [16+MAGW-1:0]      m1_side_ff;
   logic signed [AW+31:0]   m1_rnd;
   logic signed [AW-1:0]    m2_r_ff, m2_ny_ff;
   logic [MAGW-1:0]         m2_mag_ff;

   assign m1_rnd = m1_prod_ff + ((AW+32)'(1) <<< 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= c1_valid;
         m2_valid_ff <= m1_valid_ff;
      end
      m1_prod_ff <= c1_mag * INV_GAIN_Q30;
      m1_roll_ff <= c1_roll;
      m1_side_ff <= c1_side;
      m2_r_ff    <= AW'(m1_rnd >>> 30);
      m2_ny_ff   <= -(AW'($signed(m1_side_ff[16+MAGW-1:MAGW])) <<< ACC_GUARD);
      m2_mag_ff  <= m1_side_ff[MAGW-1:0];
      m2_roll_ff <= m1_roll_ff;
   end

   // ---- pitch: vectoring on (r, -ax) ----
   logic             c2_valid;
   angle_type        c2_pitch;
   logic [ZW+MAGW-1:0] c2_side;

   tcc_cordic #(.W(AW), .STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(ZW+MAGW)) u_pitch (
      .clock    (clock),
      .reset    (reset),
      .in_valid (m2_valid_ff),
      .in_x     (m2_r_ff),
      .in_y     (m2_ny_ff),
      .in_z     ('0),
      .in_side  ({m2_roll_ff, m2_mag_ff}),
      .out_valid(c2_valid),
      .out_x    (),
      .out_y    (),
      .out_z    (c2_pitch),
      .out_side (c2_side)
   );

   // ---- sin/cos of roll and of pitch, side by side ----
   logic                 c3_valid, c4_valid;
   logic signed [AW-1:0] cph, sph, cth, sth;
   logic [2*ZW-1:0]      c3_side;
   logic [MAGW-1:0]      c4_side;
   angle_type            c2_roll;

   assign c2_roll = c2_side[ZW+MAGW-1:MAGW];

   tcc_cordic #(.W(AW), .STAGES(CORDIC_STAGES), .ROTATE(1'b1), .SIDE_W(2*ZW)) u_roll_sc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c2_valid),
      .in_x     ('0),
      .in_y     ('0),
      .in_z     (c2_roll),
      .in_side  ({c2_roll, c2_pitch}),
      .out_valid(c3_valid),
      .out_x    (cph),
      .out_y    (sph),
      .out_z    (),
      .out_side (c3_side)
   );

   tcc_cordic #(.W(AW), .STAGES(CORDIC_STAGES), .ROTATE(1'b1), .SIDE_W(MAGW)) u_pitch_sc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c2_valid),
      .in_x     ('0),
      .in_y     ('0),
      .in_z     (c2_pitch),
      .in_side  (c2_side[MAGW-1:0]),
      .out_valid(c4_valid),
      .out_x    (cth),
      .out_y    (sth),
      .out_z    (),
      .out_side (c4_side)
   );

   // ---- tilt compensation: four product / sum stages ----
   logic                   p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic signed [2*AW-1:0] p1_sps_ff, p1_cps_ff;
   logic signed [AW-1:0]   p1_cph_ff, p1_sph_ff, p1_cth_ff;
   logic [2*ZW-1:0]        p1_ang_ff, p2_ang_ff, p3_ang_ff, p4_ang_ff;
   logic [MAGW-1:0]        p1_mag_ff, p2_mag_ff;
   logic signed [2*AW-1:0] p1_sps_rnd, p1_cps_rnd;
   logic signed [AW-1:0]   p2_sps_ff, p2_cps_ff;
   logic signed [HW-1:0]   p2_xa_ff, p2_ya_ff, p2_yb_ff;
   logic signed [HW-1:0]   p3_xa_ff, p3_xb_ff, p3_xc_ff, p3_y_ff;
   logic signed [HW-1:0]   p4_x_ff, p4_y_ff;
   logic signed [16:0]     mx, my, mz, p2_my, p2_mz;

   assign mx    = p1_mag_ff[50:34];
   assign my    = p1_mag_ff[33:17];
   assign mz    = p1_mag_ff[16:0];
   assign p2_my = p2_mag_ff[33:17];
   assign p2_mz = p2_mag_ff[16:0];

   assign p1_sps_rnd = p1_sps_ff + ((2*AW)'(1) <<< 29);
   assign p1_cps_rnd = p1_cps_ff + ((2*AW)'(1) <<< 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= c3_valid & c4_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
      // sin(roll)*sin(pitch), cos(roll)*sin(pitch)
      p1_sps_ff <= sph * sth;
      p1_cps_ff <= cph * sth;
      p1_cph_ff <= cph;
      p1_sph_ff <= sph;
      p1_cth_ff <= cth;
      p1_ang_ff <= c3_side;
      p1_mag_ff <= c4_side;
      // back to Q30; terms that need no rounded product
      p2_sps_ff <= AW'(p1_sps_rnd >>> 30);
      p2_cps_ff <= AW'(p1_cps_rnd >>> 30);
      p2_xa_ff  <= HW'(mx) * HW'(p1_cth_ff);
      p2_ya_ff  <= HW'(my) * HW'(p1_cph_ff);
      p2_yb_ff  <= HW'(mz) * HW'(p1_sph_ff);
      p2_ang_ff <= p1_ang_ff;
      p2_mag_ff <= p1_mag_ff;
      // remaining terms
      p3_xa_ff  <= p2_xa_ff;
      p3_xb_ff  <= HW'(p2_my) * HW'(p2_sps_ff);
      p3_xc_ff  <= HW'(p2_mz) * HW'(p2_cps_ff);
      p3_y_ff   <= p2_ya_ff - p2_yb_ff;
      p3_ang_ff <= p2_ang_ff;
      // sums
      p4_x_ff   <= p3_xa_ff + p3_xb_ff + p3_xc_ff;
      p4_y_ff   <= p3_y_ff;
      p4_ang_ff <= p3_ang_ff;
   end

   // ---- heading: vectoring on (mx_c, my_c) ----
   logic            c5_valid;
   angle_type       c5_head;
   logic [2*ZW-1:0] c5_side;

   tcc_cordic #(.W(HW), .STAGES(CORDIC_STAGES), .ROTATE(1'b0), .SIDE_W(2*ZW)) u_head (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p4_valid_ff),
      .in_x     (p4_x_ff),
      .in_y     (p4_y_ff),
      .in_z     ('0),
      .in_side  (p4_ang_ff),
      .out_valid(c5_valid),
      .out_x    (),
      .out_y    (),
      .out_z    (c5_head),
      .out_side (c5_side)
   );

   // ---- output: units, clamps, declination and wrap ----
   units_type          roll_u, pitch_u, head_u;
   logic               f1_valid_ff;
   logic signed [15:0] f1_roll_ff;
   logic signed [14:0] f1_pitch_ff;
   logic signed [17:0] f1_hsum_ff;
   logic signed [17:0] hsum_in, hwrap;

   assign roll_u  = to_units(c5_side[2*ZW-1:ZW]);
   assign pitch_u = to_units(c5_side[ZW-1:0]);
   assign head_u  = to_units(c5_head);
   assign hsum_in = 18'(head_u) + 18'(csr_decl_ff);

   // hsum stays within -55808..55807, so at most two turns go on or one comes off
   always_comb begin
      hwrap = f1_hsum_ff;
      if (f1_hsum_ff < 0) begin
         if (f1_hsum_ff + 18'sd46080 < 0) begin
            hwrap = f1_hsum_ff + 18'sd92160;
         end else begin
            hwrap = f1_hsum_ff + 18'sd46080;
         end
      end else if (f1_hsum_ff >= 18'sd46080) begin
         hwrap = f1_hsum_ff - 18'sd46080;
      end
   end

   logic               rsp_strobe_ff;
   logic signed [15:0] rsp_roll_ff;
   logic signed [14:0] rsp_pitch_ff;
   logic [15:0]        rsp_heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         f1_valid_ff   <= c5_valid;
         rsp_strobe_ff <= f1_valid_ff;
      end
      if (roll_u > ROLL_MAX) begin
         f1_roll_ff <= 16'sd23040;
      end else if (roll_u < -ROLL_MAX) begin
         f1_roll_ff <= -16'sd23040;
      end else begin
         f1_roll_ff <= 16'(roll_u);
      end
      if (pitch_u > PITCH_MAX) begin
         f1_pitch_ff <= 15'sd11520;
      end else if (pitch_u < -PITCH_MAX) begin
         f1_pitch_ff <= -15'sd11520;
      end else begin
         f1_pitch_ff <= 15'(pitch_u);
      end
      f1_hsum_ff     <= hsum_in;
      rsp_roll_ff    <= f1_roll_ff;
      rsp_pitch_ff   <= f1_pitch_ff;
      rsp_heading_ff <= 16'(hwrap);
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_roll    = rsp_roll_ff;
   assign rsp_pitch   = rsp_pitch_ff;
   assign rsp_heading = rsp_heading_ff;

endmodule

`default_nettype wire

@@ rtl/tcc_checker.sv @@
// ---------------------------------------------------------------------------
// tcc_port_checker
// Port-level checks on the compass core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [15:0] rsp_roll,
   input logic signed [14:0] rsp_pitch,
   input logic [15:0]        rsp_heading
);

   // no word survives reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result word right after reset");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_roll <= 16'sd23040) && (rsp_roll >= -16'sd23040))
      else $error("roll out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pitch <= 15'sd11520) && (rsp_pitch >= -15'sd11520))
      else $error("pitch out of range");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_heading < 16'd46080))
      else $error("heading not wrapped");

   // fully pipelined: a start is never refused
   a_no_refuse: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("start refused");

endmodule

bind tilt_compensated_compass_core tcc_port_checker u_tcc_checker (.*);

`default_nettype wire
